>>> rtl/core/spr_pkg.sv
// Shared types, constants and clamp helpers of the Q8.24 servo regulator.
package spr_pkg;

	localparam int Q_W = 32;
	localparam int FRAC_W = 24;

	typedef logic signed [Q_W-1:0] q24_t;

	localparam q24_t Q24_ONE = 32'sd16777216;
	localparam q24_t Q24_NEG_ONE = -32'sd16777216;

	// Gain scheduling and integral separation bands
	localparam q24_t SPEED_BAND_LOW = 32'sd0;
	localparam q24_t SPEED_BAND_HIGH = 32'sd16777216;
	localparam q24_t ERR_SEP_LOW = -32'sd8388608;
	localparam q24_t ERR_SEP_HIGH = 32'sd8388608;

	typedef enum logic [1:0] {
		MODE_CURRENT_PI,
		MODE_SPEED_PI,
		MODE_SPEED_PFF,
		MODE_POSITION_P
	} loop_mode_t;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOOP_MODE,
		REG_KP_NORMAL,
		REG_KP_BAND,
		REG_KI_NORMAL,
		REG_KI_SEPARATED,
		REG_KC_GAIN,
		REG_OUT_MAX,
		REG_OUT_MIN
	} reg_index_t;

	typedef struct packed {
		loop_mode_t loop_mode;
		q24_t       kp_normal;
		q24_t       kp_band;
		q24_t       ki_normal;
		q24_t       ki_separated;
		q24_t       kc_gain;
		q24_t       out_max;
		q24_t       out_min;
	} spr_cfg_t;

	// Inclusive limit: upper test wins when limits cross
	function automatic q24_t clamp_ge(input q24_t x, input q24_t hi, input q24_t lo);
		q24_t r;
		if (x >= hi) begin
			r = hi;
		end else if (x <= lo) begin
			r = lo;
		end else begin
			r = x;
		end
		return r;
	endfunction

	// Strict limit used by the position loop
	function automatic q24_t clamp_gt(input q24_t x, input q24_t hi, input q24_t lo);
		q24_t r;
		if (x > hi) begin
			r = hi;
		end else if (x < lo) begin
			r = lo;
		end else begin
			r = x;
		end
		return r;
	endfunction

endpackage

>>> rtl/core/spr_in_if.sv
// Sample channel: valid/ready handshake carrying one controller sample.
interface spr_in_if;
	import spr_pkg::*;

	logic valid;
	logic ready;
	q24_t reference;
	q24_t feedback;
	q24_t feedforward;
	q24_t shaft_speed;
	q24_t position_error;

	modport source (
		output valid, reference, feedback, feedforward, shaft_speed, position_error,
		input  ready
	);

	modport sink (
		input  valid, reference, feedback, feedforward, shaft_speed, position_error,
		output ready
	);

endinterface

>>> rtl/core/spr_out_if.sv
// Result channel: valid/ready handshake carrying one drive value.
interface spr_out_if;
	import spr_pkg::*;

	logic valid;
	logic ready;
	q24_t drive;
	logic saturated;

	modport source (
		output valid, drive, saturated,
		input  ready
	);

	modport sink (
		input  valid, drive, saturated,
		output ready
	);

endinterface

>>> rtl/core/spr_cfg_regs.sv
// Configuration register file of the servo regulator.
module spr_cfg_regs import spr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [Q_W-1:0]       cfg_data,
	output spr_cfg_t             cfg
);

	// One register written per enabled cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.loop_mode    <= MODE_CURRENT_PI;
			cfg.kp_normal    <= '0;
			cfg.kp_band      <= '0;
			cfg.ki_normal    <= '0;
			cfg.ki_separated <= '0;
			cfg.kc_gain      <= '0;
			cfg.out_max      <= Q24_ONE;
			cfg.out_min      <= Q24_NEG_ONE;
		end else if (cfg_wr_en) begin
			case (reg_index_t'(cfg_index))
				REG_LOOP_MODE:    cfg.loop_mode    <= loop_mode_t'(cfg_data[1:0]);
				REG_KP_NORMAL:    cfg.kp_normal    <= q24_t'(cfg_data);
				REG_KP_BAND:      cfg.kp_band      <= q24_t'(cfg_data);
				REG_KI_NORMAL:    cfg.ki_normal    <= q24_t'(cfg_data);
				REG_KI_SEPARATED: cfg.ki_separated <= q24_t'(cfg_data);
				REG_KC_GAIN:      cfg.kc_gain      <= q24_t'(cfg_data);
				REG_OUT_MAX:      cfg.out_max      <= q24_t'(cfg_data);
				REG_OUT_MIN:      cfg.out_min      <= q24_t'(cfg_data);
				default: begin
				end
			endcase
		end
	end

endmodule

>>> rtl/core/spr_qmul.sv
// Shared Q8.24 multiplier: registered 64-bit product, result is product >> 24.
module spr_qmul import spr_pkg::*; (
	input  logic clk,
	input  logic issue,
	input  q24_t a,
	input  q24_t b,
	output q24_t q
);

	logic signed [2*Q_W-1:0] prod_q;

	// Product holds until the next issue
	always_ff @(posedge clk) begin
		if (issue) begin
			prod_q <= a * b;
		end
	end

	// Floor shift, low word kept
	assign q = prod_q[FRAC_W+Q_W-1:FRAC_W];

endmodule

>>> rtl/core/servo_pi_regulator_q24.sv
// Q8.24 servo regulator top level: sequencer around one shared multiplier.
// Sequence, sample beat to result valid: ERR, MUL, UP, FIN in modes 0, 2 and 3; ERR, MUL,
// UP, KI, KC, SUM, FIN in mode 1. No new sample is taken until the sequencer is back in IDLE,
// as the multiplies are issued one after another to the single registered multiplier.
// A finished result waits in its output register while the next sample is taken.
// Reset (arst_n low): registers to reset values, integrator/sat/last error cleared.
module servo_pi_regulator_q24 import spr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	spr_in_if.sink               sample,
	spr_out_if.source            result,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [Q_W-1:0]       cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_MUL,
		ST_UP,
		ST_KI,
		ST_KC,
		ST_SUM,
		ST_FIN
	} state_t;

	state_t   state_q;
	spr_cfg_t cfg;

	q24_t ref_q, fdb_q, ff_q, spd_q, perr_q;
	q24_t e_q, kp_q, ki_q, up_q, u_q, acc_q;
	q24_t integ_q, sat_err_q, last_err_q;
	logic res_valid_q, res_sat_q;
	q24_t res_drive_q;

	logic mul_issue;
	q24_t mul_a, mul_b, mul_q;

	q24_t e_raw, e_next, kp_band_sel, kp_next, ki_next;
	q24_t drive_fin, sat_fin, integ_fin;
	logic sep_active, in_band, out_free, res_load;

	spr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	spr_qmul u_mul (
		.clk   (clk),
		.issue (mul_issue),
		.a     (mul_a),
		.b     (mul_b),
		.q     (mul_q)
	);

	// Error term and gain selection from the captured sample
	always_comb begin
		e_raw = ref_q - fdb_q + ((cfg.loop_mode == MODE_SPEED_PFF) ? ff_q : '0);
		case (cfg.loop_mode)
			MODE_SPEED_PI: begin
				e_next = clamp_ge(e_raw, Q24_ONE, Q24_NEG_ONE);
			end
			MODE_POSITION_P: begin
				e_next = perr_q;
			end
			default: begin
				e_next = e_raw;
			end
		endcase
		in_band     = (spd_q < SPEED_BAND_HIGH) && (spd_q > SPEED_BAND_LOW);
		kp_band_sel = in_band ? cfg.kp_band : cfg.kp_normal;
		sep_active  = (last_err_q > ERR_SEP_HIGH) || (last_err_q < ERR_SEP_LOW);
		kp_next     = cfg.kp_normal;
		ki_next     = cfg.ki_normal;
		case (cfg.loop_mode)
			MODE_SPEED_PI: begin
				kp_next = sep_active ? cfg.kp_normal : kp_band_sel;
				ki_next = sep_active ? cfg.ki_separated : cfg.ki_normal;
			end
			MODE_SPEED_PFF: begin
				kp_next = kp_band_sel;
			end
			default: begin
			end
		endcase
	end

	// Operand select for the shared multiplier
	always_comb begin
		mul_issue = 1'b0;
		mul_a     = kp_q;
		mul_b     = e_q;
		case (state_q)
			ST_MUL: begin
				mul_issue = 1'b1;
			end
			ST_UP: begin
				mul_issue = (cfg.loop_mode == MODE_CURRENT_PI) ||
					(cfg.loop_mode == MODE_SPEED_PI);
				mul_a     = ki_q;
				mul_b     = mul_q;
			end
			ST_KI: begin
				mul_issue = 1'b1;
				mul_a     = cfg.kc_gain;
				mul_b     = sat_err_q;
			end
			default: begin
			end
		endcase
	end

	// Output limiting and current-loop integrator update
	always_comb begin
		if (cfg.loop_mode == MODE_POSITION_P) begin
			drive_fin = clamp_gt(u_q, cfg.out_max, cfg.out_min);
		end else begin
			drive_fin = clamp_ge(u_q, cfg.out_max, cfg.out_min);
		end
		sat_fin   = drive_fin - u_q;
		integ_fin = clamp_ge(integ_q + mul_q, cfg.out_max, cfg.out_min);
		out_free  = !res_valid_q || result.ready;
		res_load  = (state_q == ST_FIN) && out_free;
	end

	// Sequencer, datapath registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ref_q       <= '0;
			fdb_q       <= '0;
			ff_q        <= '0;
			spd_q       <= '0;
			perr_q      <= '0;
			e_q         <= '0;
			kp_q        <= '0;
			ki_q        <= '0;
			up_q        <= '0;
			u_q         <= '0;
			acc_q       <= '0;
			integ_q     <= '0;
			sat_err_q   <= '0;
			last_err_q  <= '0;
			res_valid_q <= 1'b0;
			res_sat_q   <= 1'b0;
			res_drive_q <= '0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						ref_q   <= sample.reference;
						fdb_q   <= sample.feedback;
						ff_q    <= sample.feedforward;
						spd_q   <= sample.shaft_speed;
						perr_q  <= sample.position_error;
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					e_q        <= e_next;
					last_err_q <= e_next;
					kp_q       <= kp_next;
					ki_q       <= ki_next;
					state_q    <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_UP;
				end
				ST_UP: begin
					up_q <= mul_q;
					case (cfg.loop_mode)
						MODE_CURRENT_PI: begin
							u_q     <= mul_q + integ_q;
							state_q <= ST_FIN;
						end
						MODE_SPEED_PI: begin
							state_q <= ST_KI;
						end
						default: begin
							u_q     <= mul_q;
							state_q <= ST_FIN;
						end
					endcase
				end
				ST_KI: begin
					acc_q   <= integ_q + mul_q;
					state_q <= ST_KC;
				end
				ST_KC: begin
					integ_q <= clamp_ge(acc_q + mul_q, cfg.out_max, cfg.out_min);
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					u_q     <= up_q + integ_q;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						res_drive_q <= drive_fin;
						res_sat_q   <= (drive_fin != u_q);
						state_q     <= ST_IDLE;
						if (cfg.loop_mode != MODE_POSITION_P) begin
							sat_err_q <= sat_fin;
						end
						if (cfg.loop_mode == MODE_CURRENT_PI) begin
							integ_q <= integ_fin;
						end else if (cfg.loop_mode == MODE_SPEED_PFF) begin
							integ_q <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign sample.ready     = (state_q == ST_IDLE);
	assign result.valid     = res_valid_q;
	assign result.drive     = res_drive_q;
	assign result.saturated = res_sat_q;

endmodule

>>> rtl/core/spr_checker.sv
// Port-level assertions for the servo regulator, bound to the top level.
module spr_checker import spr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_valid,
	input logic s_ready,
	input logic r_valid,
	input logic r_ready,
	input q24_t r_drive,
	input logic r_saturated
);

	// A sample occupies the sequencer: no second sample in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_valid && s_ready) |=> !s_ready)
		else $error("sample taken while sequencer busy");

	// No fresh result can rise while the sequencer is in ERR and MUL after taking a sample
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_valid && s_ready) |=> !$rose(r_valid) ##1 !$rose(r_valid))
		else $error("result beat too early after sample");

	// Sequencer is idle whenever a new result shows up
	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(r_valid) |-> s_ready)
		else $error("result raised while sequencer busy");

	// Stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(r_valid && !r_ready) |=> (r_valid && $stable(r_drive) && $stable(r_saturated)))
		else $error("stalled result beat changed");

endmodule

bind servo_pi_regulator_q24 spr_checker u_spr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.s_valid     (sample.valid),
	.s_ready     (sample.ready),
	.r_valid     (result.valid),
	.r_ready     (result.ready),
	.r_drive     (result.drive),
	.r_saturated (result.saturated)
);
